>>> rtl/core/md4_pkg.sv
// md4 package: shared types, constants and round tables for the md4 digest block
// no dependencies
package md4_pkg;

    localparam int WordW = 32;
    localparam int InTdataW = 40;
    localparam int OutTdataW = 128;

    localparam logic [31:0] K_ROUND2 = 32'h5A827999;
    localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [5:0] LAST_ROUND = 6'd47;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0] nbytes;
        logic last;
    } item_t;

    typedef struct packed {
        logic idle;
        logic out_load;
    } core_status_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_DONE  = 5'b10000
    } core_state_t;

    function automatic logic [3:0] msg_idx(input logic [5:0] rnd);
        logic [5:0] j;
        logic [3:0] r;
        begin
            j = 6'd0;
            r = 4'd0;
            if (rnd < 6'd16) begin
                r = rnd[3:0];
            end else if (rnd < 6'd32) begin
                j = rnd - 6'd16;
                r = {j[1:0], j[3:2]};
            end else begin
                j = rnd - 6'd32;
                r = {j[0], j[1], j[2], j[3]};
            end
            return r;
        end
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
        logic [4:0] r;
        begin
            r = 5'd3;
            if (rnd < 6'd16) begin
                case (rnd[1:0])
                    2'd0: r = 5'd3;
                    2'd1: r = 5'd7;
                    2'd2: r = 5'd11;
                    default: r = 5'd19;
                endcase
            end else if (rnd < 6'd32) begin
                case (rnd[1:0])
                    2'd0: r = 5'd3;
                    2'd1: r = 5'd5;
                    2'd2: r = 5'd9;
                    default: r = 5'd13;
                endcase
            end else begin
                case (rnd[1:0])
                    2'd0: r = 5'd3;
                    2'd1: r = 5'd9;
                    2'd2: r = 5'd11;
                    default: r = 5'd15;
                endcase
            end
            return r;
        end
    endfunction

endpackage

>>> rtl/core/md4_front.sv
// md4 front: two-entry transaction queue that classifies incoming words
// depends on md4_pkg
module md4_front (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [md4_pkg::InTdataW-1:0] s_tdata, // data_word[31:0], valid_bytes[34:32]
    input  logic s_tlast,
    output logic q_valid,
    input  logic q_take,
    output md4_pkg::item_t q_item
);
    import md4_pkg::*;

    item_t mem_reg [2];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] level_reg, level_next;
    item_t in_item;
    logic push, pop;

    always_comb begin
        in_item.data = s_tdata[31:0];
        in_item.last = s_tlast;
        if (s_tlast && s_tdata[34:32] < 3'd4) begin
            in_item.nbytes = s_tdata[34:32];
        end else begin
            in_item.nbytes = 3'd4;
        end
    end

    assign s_tready = (level_reg != 2'd2);
    assign q_valid = (level_reg != 2'd0);
    assign q_item = mem_reg[rd_ptr_reg];
    assign push = s_tvalid && s_tready;
    assign pop = q_valid && q_take;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        level_next = level_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> rtl/core/md4_core.sv
// md4 back end: block buffer, padding sequencer, one-round-per-cycle compressor
// depends on md4_pkg
module md4_core (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    output logic q_take,
    input  md4_pkg::item_t q_item,
    output logic m_tvalid,
    input  logic m_tready,
    output logic [md4_pkg::OutTdataW-1:0] m_tdata, // digest_a, digest_b, digest_c, digest_d
    output md4_pkg::core_status_t status
);
    import md4_pkg::*;

    core_state_t state_reg, state_next;
    logic [31:0] blk_reg [16];
    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0] rnd_reg;
    logic [3:0] widx_reg;
    logic [4:0] pad_reg;
    logic need80_reg, final_reg, from_pad_reg;
    logic [63:0] len_reg;
    logic out_valid_reg;
    logic [OutTdataW-1:0] out_data_reg;

    logic take, out_load;
    logic [31:0] mask, word_w, f, k, m, sum;
    logic [63:0] rot2;
    logic [4:0] s;

    assign take = (state_reg == S_IDLE) && q_valid;
    assign q_take = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
    assign status.idle = (state_reg == S_IDLE);
    assign status.out_load = out_load;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    always_comb begin
        if (q_item.nbytes[2]) begin
            mask = 32'hFFFF_FFFF;
        end else begin
            mask = (32'd1 << {q_item.nbytes[1:0], 3'b000}) - 32'd1;
        end
        word_w = q_item.data & mask;
        if (q_item.last && !q_item.nbytes[2]) begin
            word_w = word_w | ({24'd0, PAD_BYTE} << {q_item.nbytes[1:0], 3'b000});
        end
    end

    always_comb begin
        if (rnd_reg < 6'd16) begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'd0;
        end else if (rnd_reg < 6'd32) begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = K_ROUND2;
        end else begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K_ROUND3;
        end
        m = blk_reg[msg_idx(rnd_reg)];
        s = rot_amt(rnd_reg);
        sum = a_reg + f + m + k;
        rot2 = {sum, sum} << s;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    if (q_item.last) begin
                        state_next = S_PAD;
                    end else if (widx_reg == 4'd15) begin
                        state_next = S_ROUND;
                    end
                end
            end
            S_PAD: begin
                if (pad_reg == 5'd16) begin
                    state_next = S_ROUND;
                end else if (!need80_reg && pad_reg == 5'd14) begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                if (rnd_reg == LAST_ROUND) begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                if (final_reg) begin
                    state_next = S_DONE;
                end else if (from_pad_reg) begin
                    state_next = S_PAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            chain_reg[0] <= IV_A;
            chain_reg[1] <= IV_B;
            chain_reg[2] <= IV_C;
            chain_reg[3] <= IV_D;
            len_reg <= 64'd0;
            widx_reg <= 4'd0;
            pad_reg <= 5'd0;
            need80_reg <= 1'b0;
            final_reg <= 1'b0;
            from_pad_reg <= 1'b0;
            rnd_reg <= 6'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        len_reg <= len_reg + {58'd0, q_item.nbytes, 3'b000};
                        if (q_item.last) begin
                            pad_reg <= {1'b0, widx_reg} + 5'd1;
                            need80_reg <= q_item.nbytes[2];
                        end else begin
                            widx_reg <= widx_reg + 4'd1;
                            if (widx_reg == 4'd15) begin
                                rnd_reg <= 6'd0;
                                final_reg <= 1'b0;
                                from_pad_reg <= 1'b0;
                            end
                        end
                    end
                end
                S_PAD: begin
                    if (pad_reg == 5'd16) begin
                        rnd_reg <= 6'd0;
                        final_reg <= 1'b0;
                        from_pad_reg <= 1'b1;
                        pad_reg <= 5'd0;
                    end else if (need80_reg) begin
                        need80_reg <= 1'b0;
                        pad_reg <= pad_reg + 5'd1;
                    end else if (pad_reg == 5'd14) begin
                        rnd_reg <= 6'd0;
                        final_reg <= 1'b1;
                    end else begin
                        pad_reg <= pad_reg + 5'd1;
                    end
                end
                S_ROUND: begin
                    rnd_reg <= rnd_reg + 6'd1;
                end
                S_ADD: begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                end
                S_DONE: begin
                    if (out_load) begin
                        chain_reg[0] <= IV_A;
                        chain_reg[1] <= IV_B;
                        chain_reg[2] <= IV_C;
                        chain_reg[3] <= IV_D;
                        len_reg <= 64'd0;
                        widx_reg <= 4'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            blk_reg[widx_reg] <= word_w;
        end
        if (state_reg == S_PAD && pad_reg != 5'd16) begin
            if (need80_reg) begin
                blk_reg[pad_reg[3:0]] <= {24'd0, PAD_BYTE};
            end else if (pad_reg == 5'd14) begin
                blk_reg[14] <= len_reg[31:0];
                blk_reg[15] <= len_reg[63:32];
            end else begin
                blk_reg[pad_reg[3:0]] <= 32'd0;
            end
        end
        if ((take && !q_item.last && widx_reg == 4'd15)
            || (state_reg == S_PAD && state_next == S_ROUND)) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end else if (state_reg == S_ROUND) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= rot2[63:32];
        end
        if (out_load) begin
            out_data_reg <= {chain_reg[3], chain_reg[2], chain_reg[1], chain_reg[0]};
        end
    end

endmodule

>>> rtl/core/md4_message_digest.sv
// md4 digest top level: front queue feeding the padding and compression back end
// depends on md4_pkg, md4_front, md4_core
//
// Streams a message in as 32-bit words (first byte in bits 7..0) and returns
// the 128-bit MD4 digest as one transaction after the word marked by s_tlast.
// valid_bytes in s_tdata[34:32] counts the valid low bytes of the last word
// (0 to 4, larger values act as 4) and is ignored on other words. The back
// end stores each word while idle; every 16th word and every padding block
// then runs the 48-round compressor (one round per cycle) and the chaining
// add. The end of a message runs the padding sequencer plus one or two
// compressions. A two-entry queue accepts up to two words while the back
// end compresses, and the digest register lets a new message begin while
// the digest is still held.
module md4_message_digest (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [md4_pkg::InTdataW-1:0] s_tdata, // data_word[31:0], valid_bytes[34:32]
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    output logic [md4_pkg::OutTdataW-1:0] m_tdata // digest_a, digest_b, digest_c, digest_d
);
    import md4_pkg::*;

    logic q_valid, q_take;
    item_t q_item;
    core_status_t status;

    md4_front u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .q_valid(q_valid),
        .q_take(q_take),
        .q_item(q_item)
    );

    md4_core u_core (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_valid(q_valid),
        .q_take(q_take),
        .q_item(q_item),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .status(status)
    );

`ifndef SYNTHESIS
    a_queue_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !q_take) |=> q_valid)
        else $error("queued word lost while back end busy");

    a_digest_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(status.out_load))
        else $error("digest shown without a load");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        status.out_load |-> (!m_tvalid || m_tready))
        else $error("digest overwritten before taken");
`endif

endmodule
